@@ sv/assert_macros.svh @@
// assertion macros for the checker module of the control group execute block
// expects a clock named aclk and an active-low reset named aresetn in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define CCGE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// property checked on every clock edge, reset included
`define CCGE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

@@ sv/ccge_pkg.sv @@
// shared types, opcode grid names, flag masks and decode helpers for the
// control group execute block; no dependencies
`timescale 1ns / 1ps

package ccge_pkg;

    // stack store geometry
    localparam int STACK_DEPTH_DEFAULT = 256;
    localparam int BANK_ROWS_DEFAULT   = STACK_DEPTH_DEFAULT / 3;
    localparam int STACK_BANKS         = 5;
    localparam int BANK_W              = 3;
    localparam int POP_LANES           = 3;
    localparam int SP_SPAN             = 256;
    localparam logic [7:0] SP_RESET    = 8'hFD;

    // status bit positions and masks
    localparam int FLAG_C_BIT = 0;
    localparam int FLAG_Z_BIT = 1;
    localparam int FLAG_I_BIT = 2;
    localparam int FLAG_D_BIT = 3;
    localparam int FLAG_B_BIT = 4;
    localparam int FLAG_V_BIT = 6;
    localparam int FLAG_N_BIT = 7;
    localparam logic [7:0] FLAG_B       = 8'b0001_0000;
    localparam logic [7:0] FLAG_ONE     = 8'b0010_0000;
    localparam logic [7:0] PULL_MASK    = 8'b1100_1111;

    // addressing columns (opcode bits 4..2)
    localparam logic [2:0] COL_IMM = 3'd0;
    localparam logic [2:0] COL_ZP  = 3'd1;
    localparam logic [2:0] COL_STK = 3'd2;
    localparam logic [2:0] COL_ABS = 3'd3;
    localparam logic [2:0] COL_REL = 3'd4;
    localparam logic [2:0] COL_ZPX = 3'd5;
    localparam logic [2:0] COL_FLG = 3'd6;
    localparam logic [2:0] COL_ABX = 3'd7;

    // operation rows (opcode bits 7..5), named after the immediate column, STY after zero page
    localparam logic [2:0] ROW_BRK = 3'd0;
    localparam logic [2:0] ROW_JSR = 3'd1;
    localparam logic [2:0] ROW_RTI = 3'd2;
    localparam logic [2:0] ROW_RTS = 3'd3;
    localparam logic [2:0] ROW_STY = 3'd4;
    localparam logic [2:0] ROW_LDY = 3'd5;
    localparam logic [2:0] ROW_CPY = 3'd6;
    localparam logic [2:0] ROW_CPX = 3'd7;

    typedef enum logic [4:0] {
        OP_NOP, OP_BRK, OP_JSR, OP_RTI, OP_RTS, OP_BIT, OP_JMP,
        OP_STY, OP_SHY, OP_LDY, OP_CPY, OP_CPX,
        OP_PHP, OP_PLP, OP_PHA, OP_PLA,
        OP_DEY, OP_TAY, OP_INY, OP_INX, OP_TYA,
        OP_BRANCH,
        OP_CLC, OP_SEC, OP_CLI, OP_SEI, OP_CLV, OP_CLD, OP_SED
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] cyc;
        logic       cross_penalty;
    } dec_t;

    // one instruction as held in the input register
    typedef struct packed {
        dec_t        dec;
        logic [2:0]  cmd;
        logic [15:0] eff_addr;
        logic [7:0]  mem_data;
        logic [15:0] next_pc;
        logic        page_cross;
    } ex_item_t;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] flags;
        logic [7:0] sp;
    } arch_state_t;

    typedef struct packed {
        logic [15:0] new_pc;
        logic [7:0]  acc;
        logic [7:0]  x_reg;
        logic [7:0]  y_reg;
        logic [7:0]  status;
        logic [7:0]  stack_ptr;
        logic        wr_en;
        logic [15:0] wr_addr;
        logic [7:0]  wr_data;
        logic [2:0]  cycles;
    } result_t;

    // push0 lands at sp, push1 at sp - 1
    typedef struct packed {
        logic       push0_en;
        logic [7:0] push0_data;
        logic       push1_en;
        logic [7:0] push1_data;
    } stack_wr_t;

    // bytes at sp + 1, sp + 2, sp + 3
    typedef logic [POP_LANES-1:0][7:0] pop_t;

    // map an opcode cell to its operation and base cycle count
    function automatic dec_t decode_op(input logic [2:0] cmd, input logic [2:0] column);
        dec_t d;
        d.op            = OP_NOP;
        d.cyc           = 3'd2;
        d.cross_penalty = 1'b0;
        case (column)
            COL_IMM: begin
                case (cmd)
                    ROW_BRK: begin d.op = OP_BRK; d.cyc = 3'd7; end
                    ROW_JSR: begin d.op = OP_JSR; d.cyc = 3'd6; end
                    ROW_RTI: begin d.op = OP_RTI; d.cyc = 3'd6; end
                    ROW_RTS: begin d.op = OP_RTS; d.cyc = 3'd6; end
                    ROW_LDY: d.op = OP_LDY;
                    ROW_CPY: d.op = OP_CPY;
                    ROW_CPX: d.op = OP_CPX;
                    default: d.op = OP_NOP;
                endcase
            end
            COL_ZP, COL_ABS: begin
                case (cmd)
                    ROW_JSR: d.op = OP_BIT;
                    ROW_STY: d.op = OP_STY;
                    ROW_LDY: d.op = OP_LDY;
                    ROW_CPY: d.op = OP_CPY;
                    ROW_CPX: d.op = OP_CPX;
                    default: d.op = OP_NOP;
                endcase
                if (d.op != OP_NOP) begin
                    d.cyc = (column == COL_ZP) ? 3'd3 : 3'd4;
                end
                // JMP exists only in the absolute column
                if (column == COL_ABS && cmd == ROW_RTI) begin
                    d.op  = OP_JMP;
                    d.cyc = 3'd3;
                end
                if (column == COL_ABS && cmd == ROW_RTS) begin
                    d.op  = OP_JMP;
                    d.cyc = 3'd5;
                end
            end
            COL_STK: begin
                case (cmd)
                    ROW_BRK: begin d.op = OP_PHP; d.cyc = 3'd3; end
                    ROW_JSR: begin d.op = OP_PLP; d.cyc = 3'd4; end
                    ROW_RTI: begin d.op = OP_PHA; d.cyc = 3'd3; end
                    ROW_RTS: begin d.op = OP_PLA; d.cyc = 3'd4; end
                    ROW_STY: d.op = OP_DEY;
                    ROW_LDY: d.op = OP_TAY;
                    ROW_CPY: d.op = OP_INY;
                    default: d.op = OP_INX;
                endcase
            end
            COL_REL: d.op = OP_BRANCH;
            COL_ZPX: begin
                case (cmd)
                    ROW_STY: begin d.op = OP_STY; d.cyc = 3'd4; end
                    ROW_LDY: begin d.op = OP_LDY; d.cyc = 3'd4; end
                    default: d.op = OP_NOP;
                endcase
            end
            COL_FLG: begin
                case (cmd)
                    ROW_BRK: d.op = OP_CLC;
                    ROW_JSR: d.op = OP_SEC;
                    ROW_RTI: d.op = OP_CLI;
                    ROW_RTS: d.op = OP_SEI;
                    ROW_STY: d.op = OP_TYA;
                    ROW_LDY: d.op = OP_CLV;
                    ROW_CPY: d.op = OP_CLD;
                    default: d.op = OP_SED;
                endcase
            end
            default: begin
                case (cmd)
                    ROW_STY: begin d.op = OP_SHY; d.cyc = 3'd5; end
                    ROW_LDY: begin
                        d.op            = OP_LDY;
                        d.cyc           = 3'd4;
                        d.cross_penalty = 1'b1;
                    end
                    default: d.op = OP_NOP;
                endcase
            end
        endcase
        return d;
    endfunction

    // stack pointer change of an operation, two's complement
    function automatic logic [7:0] stack_delta(input op_t op);
        logic [7:0] d;
        case (op)
            OP_JSR:         d = 8'hFE;
            OP_RTI:         d = 8'h03;
            OP_RTS:         d = 8'h02;
            OP_PHP, OP_PHA: d = 8'hFF;
            OP_PLP, OP_PLA: d = 8'h01;
            default:        d = 8'h00;
        endcase
        return d;
    endfunction

endpackage

@@ sv/ccge_stack_bank.sv @@
// one bank of the stack store: one write port, one registered read port
// with write-first bypass; depends on ccge_pkg
`timescale 1ns / 1ps

module ccge_stack_bank import ccge_pkg::*; #(
    parameter int ROWS = BANK_ROWS_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    we,
    input  logic [$clog2(ROWS)-1:0] waddr,
    input  logic [7:0]              wdata,
    input  logic                    re,
    input  logic [$clog2(ROWS)-1:0] raddr,
    output logic [7:0]              rdata
);

    logic [7:0] mem [ROWS];
    logic [7:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, a write to the same row in the same cycle wins
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= (we && waddr == raddr) ? wdata : mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/ccge_stack.sv @@
// banked stack store with per-entry valid bits and pop-lane read path
// depends on ccge_pkg and ccge_stack_bank
`timescale 1ns / 1ps

module ccge_stack import ccge_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       rd_en,
    input  logic [7:0] rd_sp,
    input  logic [7:0] wr_sp,
    input  stack_wr_t  wr,
    output pop_t       pop
);

    // slots zero and one each get a bank of their own and the rest go round
    // robin over three banks, so any three adjacent stack pointers hit
    // different banks, also where a shallow store wraps early at pointer 0xFF
    localparam int SOLO_BANK0 = STACK_BANKS - 2;
    localparam int SOLO_BANK1 = STACK_BANKS - 1;
    localparam int BANK_ROWS  = STACK_DEPTH / 3;
    localparam int SLOT_W     = $clog2(STACK_DEPTH);
    localparam int ROW_W      = $clog2(BANK_ROWS);

    logic [SLOT_W-1:0] slot_lut [SP_SPAN];
    logic [BANK_W-1:0] bank_lut [SP_SPAN];
    logic [ROW_W-1:0]  row_lut  [SP_SPAN];

    // constant map from stack pointer to slot, bank and row
    for (genvar i = 0; i < SP_SPAN; i++) begin : g_map
        localparam int S = i % STACK_DEPTH;
        localparam int B = (S == 0) ? SOLO_BANK0 :
                           ((S == 1) ? SOLO_BANK1 : (S - 2) % 3);
        localparam int R = (S < 2) ? 0 : (S - 2) / 3;
        assign slot_lut[i] = SLOT_W'(S);
        assign bank_lut[i] = BANK_W'(B);
        assign row_lut[i]  = ROW_W'(R);
    end

    logic [7:0]        l_sp   [POP_LANES];
    logic [SLOT_W-1:0] l_slot [POP_LANES];
    logic [BANK_W-1:0] l_bank [POP_LANES];
    logic [ROW_W-1:0]  l_row  [POP_LANES];
    logic [7:0]        w_sp   [2];
    logic [SLOT_W-1:0] w_slot [2];
    logic [BANK_W-1:0] w_bank [2];
    logic [ROW_W-1:0]  w_row  [2];

    // pop lanes read just above the pointer, pushes land at and below it
    for (genvar k = 0; k < POP_LANES; k++) begin : g_lane
        assign l_sp[k]   = rd_sp + 8'(k + 1);
        assign l_slot[k] = slot_lut[l_sp[k]];
        assign l_bank[k] = bank_lut[l_sp[k]];
        assign l_row[k]  = row_lut[l_sp[k]];
    end

    assign w_sp[0] = wr_sp;
    assign w_sp[1] = wr_sp - 8'd1;
    for (genvar k = 0; k < 2; k++) begin : g_wlane
        assign w_slot[k] = slot_lut[w_sp[k]];
        assign w_bank[k] = bank_lut[w_sp[k]];
        assign w_row[k]  = row_lut[w_sp[k]];
    end

    logic             b_we    [STACK_BANKS];
    logic [ROW_W-1:0] b_wrow  [STACK_BANKS];
    logic [7:0]       b_wdata [STACK_BANKS];
    logic [ROW_W-1:0] b_rrow  [STACK_BANKS];
    logic [7:0]       b_rdata [STACK_BANKS];

    // route the write and read lanes to their banks; where both pushes land
    // on one slot the later one, push1, is the byte that stays
    always_comb begin
        for (int j = 0; j < STACK_BANKS; j++) begin
            b_we[j]    = 1'b0;
            b_wrow[j]  = '0;
            b_wdata[j] = '0;
            b_rrow[j]  = '0;
            if (wr.push1_en && w_bank[1] == BANK_W'(j)) begin
                b_we[j]    = 1'b1;
                b_wrow[j]  = w_row[1];
                b_wdata[j] = wr.push1_data;
            end else if (wr.push0_en && w_bank[0] == BANK_W'(j)) begin
                b_we[j]    = 1'b1;
                b_wrow[j]  = w_row[0];
                b_wdata[j] = wr.push0_data;
            end
            for (int k = 0; k < POP_LANES; k++) begin
                if (l_bank[k] == BANK_W'(j)) begin
                    b_rrow[j] = l_row[k];
                end
            end
        end
    end

    for (genvar j = 0; j < STACK_BANKS; j++) begin : g_bank
        ccge_stack_bank #(
            .ROWS (BANK_ROWS)
        ) u_bank (
            .aclk  (aclk),
            .we    (b_we[j]),
            .waddr (b_wrow[j]),
            .wdata (b_wdata[j]),
            .re    (rd_en),
            .raddr (b_rrow[j]),
            .rdata (b_rdata[j])
        );
    end

    // entries never written read as zero
    logic [STACK_DEPTH-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (wr.push0_en) begin
                valid_reg[w_slot[0]] <= 1'b1;
            end
            if (wr.push1_en) begin
                valid_reg[w_slot[1]] <= 1'b1;
            end
        end
    end

    logic [BANK_W-1:0] lane_bank_reg [POP_LANES];
    logic              lane_vld_reg  [POP_LANES];

    // lane bookkeeping captured with the bank reads
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            for (int k = 0; k < POP_LANES; k++) begin
                lane_bank_reg[k] <= l_bank[k];
                lane_vld_reg[k]  <= valid_reg[l_slot[k]]
                                 || (wr.push0_en && w_slot[0] == l_slot[k])
                                 || (wr.push1_en && w_slot[1] == l_slot[k]);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < POP_LANES; k++) begin
            pop[k] = lane_vld_reg[k] ? b_rdata[lane_bank_reg[k]] : 8'h00;
        end
    end

endmodule

@@ sv/ccge_exec.sv @@
// execute logic: next architectural state, result word and stack pushes
// for one decoded instruction; depends on ccge_pkg
`timescale 1ns / 1ps

module ccge_exec import ccge_pkg::*; (
    input  ex_item_t    item,
    input  arch_state_t state,
    input  pop_t        pop,
    input  logic [15:0] break_vector,
    output arch_state_t state_next,
    output result_t     res,
    output stack_wr_t   stack_wr
);

    // branch condition select, opcode bits 7..6
    localparam logic [1:0] BR_ON_N = 2'd0;
    localparam logic [1:0] BR_ON_V = 2'd1;
    localparam logic [1:0] BR_ON_C = 2'd2;

    function automatic logic [7:0] with_zn(input logic [7:0] f, input logic [7:0] v);
        logic [7:0] r;
        r             = f;
        r[FLAG_Z_BIT] = (v == 8'h00);
        r[FLAG_N_BIT] = v[7];
        return r;
    endfunction

    logic [15:0] ret_addr;
    logic [8:0]  diff_y;
    logic [8:0]  diff_x;
    logic [7:0]  y_dec;
    logic [7:0]  y_inc;
    logic [7:0]  x_inc;
    logic        br_flag;
    logic        take;

    assign ret_addr = item.next_pc - 16'd1;
    assign diff_y   = {1'b0, state.y} - {1'b0, item.mem_data};
    assign diff_x   = {1'b0, state.x} - {1'b0, item.mem_data};
    assign y_dec    = state.y - 8'd1;
    assign y_inc    = state.y + 8'd1;
    assign x_inc    = state.x + 8'd1;

    // branch condition from the flag row
    always_comb begin
        case (item.cmd[2:1])
            BR_ON_N: br_flag = state.flags[FLAG_N_BIT];
            BR_ON_V: br_flag = state.flags[FLAG_V_BIT];
            BR_ON_C: br_flag = state.flags[FLAG_C_BIT];
            default: br_flag = state.flags[FLAG_Z_BIT];
        endcase
    end
    assign take = (br_flag == item.cmd[0]);

    // instruction body
    always_comb begin
        state_next  = state;
        res         = '0;
        stack_wr    = '0;
        res.new_pc  = item.next_pc;
        res.cycles  = item.dec.cyc + {2'b00, item.dec.cross_penalty & item.page_cross};
        case (item.dec.op)
            OP_BRK: begin
                state_next.flags[FLAG_B_BIT] = 1'b1;
                res.new_pc = break_vector;
            end
            OP_JSR: begin
                stack_wr.push0_en   = 1'b1;
                stack_wr.push0_data = ret_addr[15:8];
                stack_wr.push1_en   = 1'b1;
                stack_wr.push1_data = ret_addr[7:0];
                res.new_pc          = item.eff_addr;
            end
            OP_RTI: begin
                state_next.flags = pop[0] & ~FLAG_ONE;
                res.new_pc       = {pop[2], pop[1]};
            end
            OP_RTS: res.new_pc = {pop[1], pop[0]} + 16'd1;
            OP_BIT: begin
                state_next.flags[FLAG_Z_BIT] = ((state.acc & item.mem_data) == 8'h00);
                state_next.flags[FLAG_V_BIT] = item.mem_data[6];
                state_next.flags[FLAG_N_BIT] = item.mem_data[7];
            end
            OP_JMP: res.new_pc = item.eff_addr;
            OP_STY: begin
                res.wr_en   = 1'b1;
                res.wr_addr = item.eff_addr;
                res.wr_data = state.y;
            end
            OP_SHY: begin
                res.wr_en   = 1'b1;
                res.wr_addr = item.eff_addr;
                res.wr_data = state.y & (item.eff_addr[15:8] + 8'd1);
            end
            OP_LDY: begin
                state_next.y     = item.mem_data;
                state_next.flags = with_zn(state.flags, item.mem_data);
            end
            OP_CPY: begin
                state_next.flags = with_zn(state.flags, diff_y[7:0]);
                state_next.flags[FLAG_C_BIT] = ~diff_y[8];
            end
            OP_CPX: begin
                state_next.flags = with_zn(state.flags, diff_x[7:0]);
                state_next.flags[FLAG_C_BIT] = ~diff_x[8];
            end
            OP_PHP: begin
                stack_wr.push0_en   = 1'b1;
                stack_wr.push0_data = state.flags | FLAG_B | FLAG_ONE;
            end
            OP_PLP: state_next.flags = (pop[0] & PULL_MASK) | (state.flags & FLAG_B);
            OP_PHA: begin
                stack_wr.push0_en   = 1'b1;
                stack_wr.push0_data = state.acc;
            end
            OP_PLA: begin
                state_next.acc   = pop[0];
                state_next.flags = with_zn(state.flags, pop[0]);
            end
            OP_DEY: begin
                state_next.y     = y_dec;
                state_next.flags = with_zn(state.flags, y_dec);
            end
            OP_TAY: begin
                state_next.y     = state.acc;
                state_next.flags = with_zn(state.flags, state.acc);
            end
            OP_INY: begin
                state_next.y     = y_inc;
                state_next.flags = with_zn(state.flags, y_inc);
            end
            OP_INX: begin
                state_next.x     = x_inc;
                state_next.flags = with_zn(state.flags, x_inc);
            end
            OP_TYA: begin
                state_next.acc   = state.y;
                state_next.flags = with_zn(state.flags, state.y);
            end
            OP_BRANCH: begin
                if (take) begin
                    res.new_pc = item.eff_addr;
                    res.cycles = (item.eff_addr[15:8] != item.next_pc[15:8]) ? 3'd4 : 3'd3;
                end
            end
            OP_CLC: state_next.flags[FLAG_C_BIT] = 1'b0;
            OP_SEC: state_next.flags[FLAG_C_BIT] = 1'b1;
            OP_CLI: state_next.flags[FLAG_I_BIT] = 1'b0;
            OP_SEI: state_next.flags[FLAG_I_BIT] = 1'b1;
            OP_CLV: state_next.flags[FLAG_V_BIT] = 1'b0;
            OP_CLD: state_next.flags[FLAG_D_BIT] = 1'b0;
            OP_SED: state_next.flags[FLAG_D_BIT] = 1'b1;
            default: ;
        endcase
        state_next.sp = state.sp + stack_delta(item.dec.op);

        res.acc       = state_next.acc;
        res.x_reg     = state_next.x;
        res.y_reg     = state_next.y;
        res.status    = state_next.flags | FLAG_ONE;
        res.stack_ptr = state_next.sp;
    end

endmodule

@@ sv/cpu_control_group_execute.sv @@
// top level of the control group execute block: input register, execute
// logic, banked stack store and result register; depends on ccge_pkg,
// ccge_exec and ccge_stack
`timescale 1ns / 1ps

// Executes one control group instruction per word and sustains one word per
// clock: an accepted word sits in the input register while the execute logic
// computes it, then moves to the result register once that is empty or its
// word is being taken, and its result word is offered from there.
// While a finished result waits on m_ready the block still takes one more
// word into the input register and then holds s_ready low until the result
// leaves. The stack store is split into five banks with registered reads;
// the up to three bytes a return pulls are read in the acceptance cycle at
// the pointer that all earlier words leave behind, with pushes of the word
// ahead forwarded, so the rate is set by the single execute step and not by
// the store ports. Stack entries that were never pushed read as zero through
// per-entry valid bits cleared by reset, so no clearing pass runs after
// reset. The user must write the break vector through cfg_wr_en and
// cfg_wr_data only while idle; the block itself does not enforce this.
module cpu_control_group_execute import ccge_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // instruction words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [2:0]  s_column,
    input  logic [15:0] s_eff_addr,
    input  logic [7:0]  s_mem_data,
    input  logic [15:0] s_next_pc,
    input  logic        s_page_cross,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_new_pc,
    output logic [7:0]  m_acc,
    output logic [7:0]  m_x_reg,
    output logic [7:0]  m_y_reg,
    output logic [7:0]  m_status,
    output logic [7:0]  m_stack_ptr,
    output logic        m_wr_en,
    output logic [15:0] m_wr_addr,
    output logic [7:0]  m_wr_data,
    output logic [2:0]  m_cycles
);

    logic        ex_valid_reg;
    logic        ex_valid_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    ex_item_t    ex_item_reg;
    result_t     res_reg;
    arch_state_t state_reg;
    arch_state_t state_next;
    logic [7:0]  sp_front_reg;
    logic [7:0]  sp_front_next;
    logic [15:0] break_vector_reg;
    logic        accept;
    logic        ex_adv;
    dec_t        dec_in;
    result_t     res;
    stack_wr_t   stack_wr;
    stack_wr_t   stack_wr_gated;
    pop_t        pop;

    // handshake
    assign accept  = s_valid && s_ready;
    assign ex_adv  = ex_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !ex_valid_reg || ex_adv;

    assign ex_valid_next = accept ? 1'b1 : (ex_adv ? 1'b0 : ex_valid_reg);
    assign m_valid_next  = ex_adv ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // decode on entry, the pointer ahead tracks all accepted words
    assign dec_in        = decode_op(s_cmd, s_column);
    assign sp_front_next = sp_front_reg + stack_delta(dec_in.op);

    // control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            state_reg        <= '{acc: 8'h00, x: 8'h00, y: 8'h00, flags: 8'h00, sp: SP_RESET};
            sp_front_reg     <= SP_RESET;
            break_vector_reg <= '0;
        end else begin
            ex_valid_reg <= ex_valid_next;
            m_valid_reg  <= m_valid_next;
            if (ex_adv) begin
                state_reg <= state_next;
            end
            if (accept) begin
                sp_front_reg <= sp_front_next;
            end
            if (cfg_wr_en) begin
                break_vector_reg <= cfg_wr_data;
            end
        end
    end

    // input and result registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            ex_item_reg <= '{dec: dec_in, cmd: s_cmd, eff_addr: s_eff_addr,
                             mem_data: s_mem_data, next_pc: s_next_pc,
                             page_cross: s_page_cross};
        end
        if (ex_adv) begin
            res_reg <= res;
        end
    end

    ccge_exec u_exec (
        .item         (ex_item_reg),
        .state        (state_reg),
        .pop          (pop),
        .break_vector (break_vector_reg),
        .state_next   (state_next),
        .res          (res),
        .stack_wr     (stack_wr)
    );

    // pushes commit only when the word leaves the execute stage
    always_comb begin
        stack_wr_gated          = stack_wr;
        stack_wr_gated.push0_en = stack_wr.push0_en && ex_adv;
        stack_wr_gated.push1_en = stack_wr.push1_en && ex_adv;
    end

    ccge_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_sp   (sp_front_reg),
        .wr_sp   (state_reg.sp),
        .wr      (stack_wr_gated),
        .pop     (pop)
    );

    // result ports
    assign m_valid     = m_valid_reg;
    assign m_new_pc    = res_reg.new_pc;
    assign m_acc       = res_reg.acc;
    assign m_x_reg     = res_reg.x_reg;
    assign m_y_reg     = res_reg.y_reg;
    assign m_status    = res_reg.status;
    assign m_stack_ptr = res_reg.stack_ptr;
    assign m_wr_en     = res_reg.wr_en;
    assign m_wr_addr   = res_reg.wr_addr;
    assign m_wr_data   = res_reg.wr_data;
    assign m_cycles    = res_reg.cycles;

endmodule

@@ sv/ccge_checker.sv @@
// port-level checks for the control group execute block and its bind
// depends on assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccge_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_new_pc,
    input logic [7:0]  m_status,
    input logic        m_wr_en,
    input logic [15:0] m_wr_addr,
    input logic [7:0]  m_wr_data
);

    logic out_stall;
    logic wr_quiet;

    assign out_stall = m_valid && !m_ready;
    assign wr_quiet  = m_wr_en || (m_wr_addr == 16'h0000 && m_wr_data == 8'h00);

    // a stalled result word stays valid and keeps its new pc
    `CCGE_ASSERT(a_out_hold, out_stall |=> m_valid && $stable(m_new_pc), "stalled result changed")

    // an empty result register never blocks the input side
    `CCGE_ASSERT(a_ready_when_empty, !m_valid |-> s_ready, "input stalled while empty")

    // no result straight out of reset
    `CCGE_ASSERT_ALWAYS(a_reset_empty, $rose(aresetn) |-> !m_valid, "result right after reset")

    // fixed status bit and quiet write fields without a write
    `CCGE_ASSERT(a_result_form, m_valid |-> m_status[5] && wr_quiet, "malformed result word")

    // an accepted word reaches the result register
    `CCGE_ASSERT(a_accept_result, s_valid && s_ready |-> ##2 m_valid, "accepted word lost")

endmodule

bind cpu_control_group_execute ccge_checker u_ccge_checker (.*);
